>>> sv/sm4_block_cipher_ecb_cbc_top_defines.svh
// Assertion macros for the SM4 ECB/CBC block.
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_TOP_DEFINES_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SM4_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SM4_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SM4_ASSERT(label, clk, rst_n, prop, msg)
`define SM4_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> sv/sm4_pkg.sv
// Shared types, constants and functions for the SM4 block.
package sm4_pkg;
  localparam int unsigned Rounds = 32;
  localparam int unsigned RkAw = $clog2(Rounds);
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegKeyHi = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLo = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIvHi  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIvLo  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDec   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCbc   = 3'd5;

  localparam logic [31:0] Fk0 = 32'ha3b1bac6;
  localparam logic [31:0] Fk1 = 32'h56aa3350;
  localparam logic [31:0] Fk2 = 32'h677d9197;
  localparam logic [31:0] Fk3 = 32'hb27022dc;

  typedef enum logic [2:0] {
    StIdle, StExpand, StPrime, StCrypt, StOut
  } state_e;

  typedef struct packed {
    logic load_key;    // load schedule registers from key
    logic expand_step; // one key schedule round, write RAM
    logic load_block;  // load cipher state from request
    logic crypt_step;  // one cipher round
    logic rd_en;       // read round key
    logic [RkAw-1:0] rk_addr;
    logic finish;      // capture result and update chain
  } ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };
    return t[a];
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] v);
    return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] v);
    logic [31:0] b;
    b = subst_word(v);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] sched_mix(input logic [31:0] v);
    logic [31:0] b;
    b = subst_word(v);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // Byte j of the constant for round r is (4r + j) * 7 mod 256.
  function automatic logic [31:0] round_const(input logic [RkAw-1:0] r);
    logic [31:0] c;
    logic [7:0] base;
    base = 8'({r, 2'b00});
    for (int j = 0; j < 4; j++) begin
      c[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
    end
    return c;
  endfunction
endpackage

>>> sv/sm4_if.sv
// Valid/ready channel interfaces for blocks, results and register writes.
interface sm4_blk_if;
  logic valid;
  logic ready;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic first_block;
  modport source (output valid, block_hi, block_lo, first_block, input ready);
  modport sink (input valid, block_hi, block_lo, first_block, output ready);
endinterface

interface sm4_res_if;
  logic valid;
  logic ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

interface sm4_cfg_if;
  logic valid;
  logic ready;
  logic [sm4_pkg::CfgIdxW-1:0] index;
  logic [sm4_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sm4_block_cipher_ecb_cbc_top.sv
// Top level of the SM4 ECB/CBC block cipher.
//
//  channel  dir  handshake            payload
//  cfg_w    in   cfg_w.valid/ready    index, data (key, IV, decrypt, CBC)
//  blk_in   in   blk_in.valid/ready   block_hi, block_lo, first_block
//  res_out  out  res_out.valid/ready  result_hi, result_lo
//
// An accepted request is loaded, primed with a key read and run through 32
// rounds on the shared round unit; key expansion runs first on the first
// request after reset or a key write. Round keys sit in a 32x32 RAM.
// Reset clears config, chaining and control; no clearing pass is needed.
// A finished result waits in the output register; the next request is taken
// meanwhile and only its hand-off stalls on a full output register.
`include "sm4_block_cipher_ecb_cbc_top_defines.svh"
module sm4_block_cipher_ecb_cbc_top (
  input logic     clk_i,
  input logic     rst_ni,
  sm4_cfg_if.sink cfg_w,
  sm4_blk_if.sink blk_in,
  sm4_res_if.source res_out
);
  sm4_pkg::ctrl_t ctrl;
  logic keys_ready, dec;

  // Config is always taken; the caller writes only while idle.
  assign cfg_w.ready = 1'b1;

  sm4_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (blk_in.valid),
    .in_ready_o   (blk_in.ready),
    .out_valid_o  (res_out.valid),
    .out_ready_i  (res_out.ready),
    .keys_ready_i (keys_ready),
    .dec_i        (dec),
    .ctrl_o       (ctrl)
  );

  sm4_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_we_i      (cfg_w.valid),
    .cfg_idx_i     (cfg_w.index),
    .cfg_data_i    (cfg_w.data),
    .block_hi_i    (blk_in.block_hi),
    .block_lo_i    (blk_in.block_lo),
    .first_block_i (blk_in.first_block),
    .keys_ready_o  (keys_ready),
    .dec_o         (dec),
    .result_hi_o   (res_out.result_hi),
    .result_lo_o   (res_out.result_lo)
  );

  // Expansion never overlaps a cipher round.
  `SM4_ASSERT(a_no_overlap, clk_i, rst_ni, !(ctrl.expand_step && ctrl.crypt_step), "expand and crypt overlap")
  // Keys are ready once rounds run.
  `SM4_ASSERT(a_keys_for_crypt, clk_i, rst_ni, !ctrl.crypt_step || keys_ready, "crypt without keys")
  // A result is captured only when the output register is free or draining.
  `SM4_ASSERT(a_no_overwrite, clk_i, rst_ni, !ctrl.finish || !res_out.valid || res_out.ready, "result overwritten")
  // A finish always leaves a valid result behind.
  `SM4_ASSERT_NEXT(a_finish_valid, clk_i, rst_ni, ctrl.finish, res_out.valid, "finish lost")
endmodule

>>> sv/sm4_ram.sv
// Generic single-port-write, registered-read RAM.
module sm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/sm4_ctrl.sv
// Sequencer for key expansion, cipher rounds and result hand-off.
module sm4_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           keys_ready_i,
  input  logic           dec_i,
  output sm4_pkg::ctrl_t ctrl_o
);
  sm4_pkg::state_e state_q, state_d;
  logic [sm4_pkg::RkAw-1:0] cnt_q, cnt_d;
  logic busy_out_q, busy_out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sm4_pkg::StIdle;
      cnt_q      <= '0;
      busy_out_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      busy_out_q <= busy_out_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    busy_out_d = busy_out_q;
    ctrl_o = '0;
    in_ready_o = 1'b0;
    if (busy_out_q && out_ready_i) begin
      busy_out_d = 1'b0;
    end
    case (state_q)
      sm4_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_block = 1'b1;
          cnt_d = '0;
          if (!keys_ready_i) begin
            ctrl_o.load_key = 1'b1;
            state_d = sm4_pkg::StExpand;
          end else begin
            state_d = sm4_pkg::StPrime;
          end
        end
      end
      sm4_pkg::StExpand: begin
        ctrl_o.expand_step = 1'b1;
        ctrl_o.rk_addr = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sm4_pkg::RkAw'(sm4_pkg::Rounds - 1)) begin
          state_d = sm4_pkg::StPrime;
        end
      end
      sm4_pkg::StPrime: begin
        ctrl_o.rd_en = 1'b1;
        ctrl_o.rk_addr = dec_i ? ~cnt_q : cnt_q;
        state_d = sm4_pkg::StCrypt;
      end
      sm4_pkg::StCrypt: begin
        ctrl_o.crypt_step = 1'b1;
        ctrl_o.rd_en = 1'b1;
        ctrl_o.rk_addr = dec_i ? ~(cnt_q + 1'b1) : (cnt_q + 1'b1);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sm4_pkg::RkAw'(sm4_pkg::Rounds - 1)) begin
          state_d = sm4_pkg::StOut;
        end
      end
      sm4_pkg::StOut: begin
        if (!busy_out_q || out_ready_i) begin
          ctrl_o.finish = 1'b1;
          busy_out_d = 1'b1;
          state_d = sm4_pkg::StIdle;
        end
      end
      default: state_d = sm4_pkg::StIdle;
    endcase
  end

  assign out_valid_o = busy_out_q;
endmodule

>>> sv/sm4_datapath.sv
// Key schedule, round function, chaining and result register.
module sm4_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sm4_pkg::ctrl_t ctrl_i,
  input  logic           cfg_we_i,
  input  logic [sm4_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sm4_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [63:0]    block_hi_i,
  input  logic [63:0]    block_lo_i,
  input  logic           first_block_i,
  output logic           keys_ready_o,
  output logic           dec_o,
  output logic [63:0]    result_hi_o,
  output logic [63:0]    result_lo_o
);
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic dec_q, cbc_q, keys_ready_q, keys_ready_d;
  logic [63:0] chain_hi_q, chain_hi_d, chain_lo_q, chain_lo_d;
  logic [63:0] in_hi_q, in_lo_q;
  logic [31:0] k_q [4];
  logic [31:0] x_q [4];
  logic [31:0] nk, nx, rk;
  logic [63:0] res_hi_q, res_lo_q, ch_hi, ch_lo, c_hi, c_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0; key_lo_q <= '0; iv_hi_q <= '0; iv_lo_q <= '0;
      dec_q <= 1'b0; cbc_q <= 1'b0; keys_ready_q <= 1'b0;
      chain_hi_q <= '0; chain_lo_q <= '0;
    end else begin
      keys_ready_q <= keys_ready_d;
      chain_hi_q <= chain_hi_d;
      chain_lo_q <= chain_lo_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sm4_pkg::RegKeyHi: key_hi_q <= cfg_data_i;
          sm4_pkg::RegKeyLo: key_lo_q <= cfg_data_i;
          sm4_pkg::RegIvHi:  iv_hi_q <= cfg_data_i;
          sm4_pkg::RegIvLo:  iv_lo_q <= cfg_data_i;
          sm4_pkg::RegDec:   dec_q <= cfg_data_i[0];
          sm4_pkg::RegCbc:   cbc_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    keys_ready_d = keys_ready_q;
    if (ctrl_i.expand_step) keys_ready_d = 1'b1;
    if (cfg_we_i && (cfg_idx_i == sm4_pkg::RegKeyHi || cfg_idx_i == sm4_pkg::RegKeyLo)) begin
      keys_ready_d = 1'b0;
    end
  end

  // Chain value seen by this block: IV on a first block in CBC.
  assign ch_hi = (cbc_q && first_block_i) ? iv_hi_q : chain_hi_q;
  assign ch_lo = (cbc_q && first_block_i) ? iv_lo_q : chain_lo_q;

  assign nk = k_q[0] ^ sm4_pkg::sched_mix(k_q[1] ^ k_q[2] ^ k_q[3]
              ^ sm4_pkg::round_const(ctrl_i.rk_addr));
  assign nx = x_q[0] ^ sm4_pkg::round_mix(x_q[1] ^ x_q[2] ^ x_q[3] ^ rk);

  sm4_ram #(.Width(32), .Depth(sm4_pkg::Rounds)) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.expand_step),
    .waddr_i (ctrl_i.rk_addr),
    .wdata_i (nk),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (ctrl_i.rk_addr),
    .rdata_o (rk)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_key) begin
      k_q[0] <= key_hi_q[63:32] ^ sm4_pkg::Fk0;
      k_q[1] <= key_hi_q[31:0] ^ sm4_pkg::Fk1;
      k_q[2] <= key_lo_q[63:32] ^ sm4_pkg::Fk2;
      k_q[3] <= key_lo_q[31:0] ^ sm4_pkg::Fk3;
    end else if (ctrl_i.expand_step) begin
      k_q[0] <= k_q[1]; k_q[1] <= k_q[2]; k_q[2] <= k_q[3]; k_q[3] <= nk;
    end
    if (ctrl_i.load_block) begin
      in_hi_q <= block_hi_i;
      in_lo_q <= block_lo_i;
      if (cbc_q && !dec_q) begin
        x_q[0] <= block_hi_i[63:32] ^ ch_hi[63:32];
        x_q[1] <= block_hi_i[31:0] ^ ch_hi[31:0];
        x_q[2] <= block_lo_i[63:32] ^ ch_lo[63:32];
        x_q[3] <= block_lo_i[31:0] ^ ch_lo[31:0];
      end else begin
        x_q[0] <= block_hi_i[63:32]; x_q[1] <= block_hi_i[31:0];
        x_q[2] <= block_lo_i[63:32]; x_q[3] <= block_lo_i[31:0];
      end
    end else if (ctrl_i.crypt_step) begin
      x_q[0] <= x_q[1]; x_q[1] <= x_q[2]; x_q[2] <= x_q[3]; x_q[3] <= nx;
    end
    if (ctrl_i.finish) begin
      res_hi_q <= (cbc_q && dec_q) ? (c_hi ^ chain_hi_q) : c_hi;
      res_lo_q <= (cbc_q && dec_q) ? (c_lo ^ chain_lo_q) : c_lo;
    end
  end

  assign c_hi = {x_q[3], x_q[2]};
  assign c_lo = {x_q[1], x_q[0]};

  always_comb begin
    chain_hi_d = chain_hi_q;
    chain_lo_d = chain_lo_q;
    if (ctrl_i.load_block && cbc_q) begin
      chain_hi_d = ch_hi;
      chain_lo_d = ch_lo;
    end
    if (ctrl_i.finish && cbc_q) begin
      chain_hi_d = dec_q ? in_hi_q : c_hi;
      chain_lo_d = dec_q ? in_lo_q : c_lo;
    end
  end

  assign keys_ready_o = keys_ready_q;
  assign dec_o = dec_q;
  assign result_hi_o = res_hi_q;
  assign result_lo_o = res_lo_q;
endmodule

>>> dv/sm4_cipher_checker.sv
// Checker for the SM4 ECB/CBC block: watches all channels and compares results.
module sm4_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sm4_cfg_if          cfg_w,
  sm4_blk_if          blk_in,
  sm4_res_if          res_out,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_seen_o
);
  import sm4_pkg::*;

  logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
  logic        decrypt_mode, cbc_mode;
  logic [31:0] sched_keys [32];
  logic        sched_valid;
  logic [63:0] chain_hi, chain_lo;
  logic [127:0] expected_blocks [$];

  localparam logic [31:0] FamilyKey [4] = '{32'ha3b1bac6, 32'h56aa3350,
                                            32'h677d9197, 32'hb27022dc};
  localparam logic [7:0] SboxTab [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(logic [31:0] v);
    return {SboxTab[v[31:24]], SboxTab[v[23:16]], SboxTab[v[15:8]], SboxTab[v[7:0]]};
  endfunction

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] data_lin(logic [31:0] v);
    logic [31:0] b;
    b = tau(v);
    return b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
  endfunction

  function automatic logic [31:0] key_lin(logic [31:0] v);
    logic [31:0] b;
    b = tau(v);
    return b ^ rol(b, 13) ^ rol(b, 23);
  endfunction

  task automatic expand_schedule();
    logic [31:0] k [4];
    logic [31:0] ck, nk;
    k[0] = key_hi[63:32] ^ FamilyKey[0];
    k[1] = key_hi[31:0] ^ FamilyKey[1];
    k[2] = key_lo[63:32] ^ FamilyKey[2];
    k[3] = key_lo[31:0] ^ FamilyKey[3];
    for (int r = 0; r < 32; r++) begin
      for (int j = 0; j < 4; j++) ck[31-8*j -: 8] = 8'((4 * r + j) * 7);
      nk = k[0] ^ key_lin(k[1] ^ k[2] ^ k[3] ^ ck);
      sched_keys[r] = nk;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
    end
    sched_valid = 1'b1;
  endtask

  function automatic logic [127:0] sm4_rounds(logic [127:0] blk, logic rev);
    logic [31:0] x [4];
    logic [31:0] nx;
    x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
    for (int r = 0; r < 32; r++) begin
      nx = x[0] ^ data_lin(x[1] ^ x[2] ^ x[3] ^ sched_keys[rev ? 31 - r : r]);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  task automatic predict_block(logic [127:0] blk, logic first);
    logic [127:0] res;
    if (!sched_valid) expand_schedule();
    if (cbc_mode) begin
      if (first) begin
        chain_hi = iv_hi;
        chain_lo = iv_lo;
      end
      if (decrypt_mode) begin
        res = sm4_rounds(blk, 1'b1) ^ {chain_hi, chain_lo};
        {chain_hi, chain_lo} = blk;
      end else begin
        res = sm4_rounds(blk ^ {chain_hi, chain_lo}, 1'b0);
        {chain_hi, chain_lo} = res;
      end
    end else begin
      res = sm4_rounds(blk, decrypt_mode);
    end
    expected_blocks.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] exp_blk;
    if (!rst_ni) begin
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      decrypt_mode = 1'b0; cbc_mode = 1'b0;
      sched_valid = 1'b0; chain_hi = '0; chain_lo = '0;
      expected_blocks.delete();
      fail_count_o = 0;
      results_seen_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          RegKeyHi: begin key_hi = cfg_w.data; sched_valid = 1'b0; end
          RegKeyLo: begin key_lo = cfg_w.data; sched_valid = 1'b0; end
          RegIvHi:  iv_hi = cfg_w.data;
          RegIvLo:  iv_lo = cfg_w.data;
          RegDec:   decrypt_mode = cfg_w.data[0];
          RegCbc:   cbc_mode = cfg_w.data[0];
          default: ;
        endcase
      end
      if (blk_in.valid && blk_in.ready)
        predict_block({blk_in.block_hi, blk_in.block_lo}, blk_in.first_block);
      if (res_out.valid && res_out.ready) begin
        results_seen_o++;
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h_%h", $time, res_out.result_hi,
                   res_out.result_lo);
          fail_count_o++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (res_out.result_hi !== exp_blk[127:64]) begin
            $display("%0t: result_hi expected %h actual %h", $time, exp_blk[127:64],
                     res_out.result_hi);
            fail_count_o++;
          end
          if (res_out.result_lo !== exp_blk[63:0]) begin
            $display("%0t: result_lo expected %h actual %h", $time, exp_blk[63:0],
                     res_out.result_lo);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_blocks.size();
    end
  end
endmodule

>>> dv/sm4_block_cipher_ecb_cbc_top_tb.sv
// Testbench top for the SM4 ECB/CBC block: stimulus, pacing and verdict.
module sm4_block_cipher_ecb_cbc_top_tb;
  import sm4_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sm4_cfg_if cfg_w ();
  sm4_blk_if blk_in ();
  sm4_res_if res_out ();

  int unsigned fail_count, pending, results_seen;
  int unsigned cycle_count;
  int unsigned blocks_sent;
  int unsigned settings_used;
  bit          long_holdoff;

  localparam int unsigned CycleLimit = 600000;

  sm4_block_cipher_ecb_cbc_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_w(cfg_w), .blk_in(blk_in), .res_out(res_out)
  );

  sm4_cipher_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_w(cfg_w), .blk_in(blk_in), .res_out(res_out),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run at a generous cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Draw a gap: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  // Receiver side: random stalls, plus one long hold-off so the input backs up.
  initial begin
    int unsigned n;
    res_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_holdoff) begin
        res_out.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_holdoff = 1'b0;
      end
      n = gap_len();
      if (n > 0 && $urandom_range(3) == 0) begin
        res_out.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res_out.ready <= 1'b1;
    end
  end

  // Write one register, then drop valid and idle so back-to-back writes never collide.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data <= value;
    do @(posedge clk_i); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one request and hold it until accepted; optionally idle first.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic first, bit pace);
    int unsigned n;
    n = pace ? gap_len() : 0;
    if (n > 0) begin
      blk_in.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    blk_in.valid <= 1'b1;
    blk_in.block_hi <= hi;
    blk_in.block_lo <= lo;
    blk_in.first_block <= first;
    do @(posedge clk_i); while (!blk_in.ready);
    blocks_sent++;
  endtask

  // Drop valid and wait until every prediction has been matched, plus a margin.
  task automatic drain();
    blk_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    int unsigned p;
    p = $urandom_range(9);
    v = {$urandom, $urandom};
    if (p == 0) v = '0;
    else if (p == 1) v = '1;
    return v;
  endfunction

  task automatic write_all(logic [63:0] khi, logic [63:0] klo, logic [63:0] ihi,
                           logic [63:0] ilo, logic dec, logic cbc);
    write_reg(RegKeyHi, khi);
    write_reg(RegKeyLo, klo);
    write_reg(RegIvHi, ihi);
    write_reg(RegIvLo, ilo);
    write_reg(RegDec, {63'd0, dec});
    write_reg(RegCbc, {63'd0, cbc});
    settings_used++;
  endtask

  initial begin
    int unsigned msg_len;
    logic [CfgIdxW-1:0] bad_idx;
    cfg_w.valid = 1'b0;
    cfg_w.index = '0;
    cfg_w.data = '0;
    blk_in.valid = 1'b0;
    blk_in.block_hi = '0;
    blk_in.block_lo = '0;
    blk_in.first_block = 1'b0;
    cycle_count = 0;
    long_holdoff = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, standard test vector, extremes, every mode.
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b0);
    drain();
    write_all(64'h0123456789abcdef, 64'hfedcba9876543210, '0, '0, 1'b0, 1'b0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0);
    send_block('0, '0, 1'b1, 1'b0);
    send_block('1, '1, 1'b0, 1'b0);
    drain();
    write_reg(RegDec, 64'd1);
    send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0, 1'b0);
    send_block('1, '0, 1'b0, 1'b0);
    drain();
    // CBC with an all-ones key and a zero IV, then an all-ones IV in both directions.
    write_all('1, '1, '0, '0, 1'b0, 1'b1);
    send_block('0, '0, 1'b1, 1'b0);
    send_block('1, '1, 1'b0, 1'b0);
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0, 1'b0);
    drain();
    write_reg(RegIvHi, '1);
    write_reg(RegIvLo, '1);
    send_block('0, '1, 1'b0, 1'b0);  // new IV not used until a first block
    send_block('0, '1, 1'b1, 1'b0);
    drain();
    write_reg(RegDec, 64'd1);
    send_block('1, '0, 1'b1, 1'b0);
    send_block('0, '1, 1'b0, 1'b0);
    drain();
    // A switch to ECB and ignored out-of-range register indices.
    write_reg(RegCbc, 64'd0);
    send_block(64'h1, 64'h2, 1'b1, 1'b0);
    drain();
    bad_idx = 3'd6;
    write_reg(bad_idx, '1);
    bad_idx = 3'd7;
    write_reg(bad_idx, '1);
    write_reg(RegCbc, 64'hfffffffffffffffe);  // only bit 0 counts
    write_reg(RegDec, 64'd0);
    send_block(64'h3, 64'h4, 1'b0, 1'b0);
    drain();

    // Random phases: new settings, then messages of random content.
    for (int phase = 0; blocks_sent < 1300; phase++) begin
      write_all(rand64(), rand64(), rand64(), rand64(), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      if (phase == 3) long_holdoff = 1'b1;
      for (int m = 0; m < 6; m++) begin
        msg_len = $urandom_range(8, 1);
        for (int b = 0; b < msg_len; b++)
          send_block(rand64(), rand64(), (b == 0) ^ ($urandom_range(15) == 0),
                     phase != 3);
      end
      drain();
      // Sometimes rewrite only the direction, keeping the key schedule.
      if ($urandom_range(2) == 0) begin
        write_reg(RegDec, {$urandom, $urandom});
        send_block(rand64(), rand64(), 1'b1, 1'b1);
        send_block(rand64(), rand64(), 1'b0, 1'b1);
        drain();
      end
    end

    $display("%0d requests sent, %0d results checked over %0d register settings",
             blocks_sent, results_seen, settings_used);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/sm4_pkg.sv
sv/sm4_if.sv
sv/sm4_ram.sv
sv/sm4_ctrl.sv
sv/sm4_datapath.sv
sv/sm4_block_cipher_ecb_cbc_top.sv
dv/sm4_cipher_checker.sv
dv/sm4_block_cipher_ecb_cbc_top_tb.sv
